[design/rtpv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rtpv_pkg;

    // op codes
    localparam logic [1:0] OP_POINT  = 2'd0;
    localparam logic [1:0] OP_VECTOR = 2'd1;
    localparam logic [1:0] OP_YAW    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_ROT_ROW0 = 3'd0;
    localparam logic [2:0] CFG_ROT_ROW1 = 3'd1;
    localparam logic [2:0] CFG_ROT_ROW2 = 3'd2;
    localparam logic [2:0] CFG_TRANS_X  = 3'd3;
    localparam logic [2:0] CFG_TRANS_Y  = 3'd4;
    localparam logic [2:0] CFG_TRANS_Z  = 3'd5;

    localparam int          ROW_WIDTH = 48;
    localparam logic [47:0] ROW0_RST  = 48'h0000_0000_4000;
    localparam logic [47:0] ROW1_RST  = 48'h0000_4000_0000;
    localparam logic [47:0] ROW2_RST  = 48'h4000_0000_0000;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // rotation matrix, column 0 in the low 16 bits of each row
    typedef struct packed {
        logic [47:0] row2;
        logic [47:0] row1;
        logic [47:0] row0;
    } rot_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_angle(input logic [4:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

[design/rigid_transform_point_vector_yaw.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Handshake            | Payload
// s_ (item) | in        | s_valid / s_ready    | op, x/y/z_in, angle_in
// m_ (item) | out       | m_valid / m_ready    | x/y/z_out, angle_out, saturated
// cfg       | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle unless m_ready stalls the output.
// The yaw path sets the depth: fold, CORDIC_STAGES rotation cells, heading
// multiply, heading sum, CORDIC_STAGES vectoring cells, output register.
// The whole pipeline advances when the output register is empty or taken;
// a stall on m_ready holds every stage and drops s_ready in the same cycle.
// Reset clears valid bits and loads identity rotation and zero translation.
module rigid_transform_point_vector_yaw #(
    parameter int COORD_WIDTH   = 32,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_op,
    input  wire logic signed [COORD_WIDTH-1:0] s_x_in,
    input  wire logic signed [COORD_WIDTH-1:0] s_y_in,
    input  wire logic signed [COORD_WIDTH-1:0] s_z_in,
    input  wire logic signed [ANGLE_WIDTH-1:0] s_angle_in,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic signed [COORD_WIDTH-1:0]  m_x_out,
    output logic signed [COORD_WIDTH-1:0]  m_y_out,
    output logic signed [COORD_WIDTH-1:0]  m_z_out,
    output logic signed [ANGLE_WIDTH-1:0]  m_angle_out,
    output logic                           m_saturated,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [47:0]               cfg_data
);
    localparam int S    = CORDIC_STAGES;
    localparam int DEPTH = 2 * S + 3;      // pipeline stages ahead of output reg
    localparam int CDLY = DEPTH - 3;        // coordinate path is three deep
    localparam int RW   = 33;               // heading rotation width
    localparam int PW   = 16 + RW;          // heading product width
    localparam int VW   = 52;               // vectoring width

    // ---------------- configuration ----------------
    rtpv_pkg::rot_t                rot_reg;
    logic signed [COORD_WIDTH-1:0] tx_reg, ty_reg, tz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg.row0 <= rtpv_pkg::ROW0_RST;
            rot_reg.row1 <= rtpv_pkg::ROW1_RST;
            rot_reg.row2 <= rtpv_pkg::ROW2_RST;
            tx_reg       <= '0;
            ty_reg       <= '0;
            tz_reg       <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rtpv_pkg::CFG_ROT_ROW0: rot_reg.row0 <= cfg_data;
                rtpv_pkg::CFG_ROT_ROW1: rot_reg.row1 <= cfg_data;
                rtpv_pkg::CFG_ROT_ROW2: rot_reg.row2 <= cfg_data;
                rtpv_pkg::CFG_TRANS_X:  tx_reg <= cfg_data[COORD_WIDTH-1:0];
                rtpv_pkg::CFG_TRANS_Y:  ty_reg <= cfg_data[COORD_WIDTH-1:0];
                rtpv_pkg::CFG_TRANS_Z:  tz_reg <= cfg_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic m_valid_reg;
    logic adv;
    logic       vld_reg [DEPTH];
    logic [1:0] op_reg  [DEPTH];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) vld_reg[k] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < DEPTH; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg[0] <= s_op;
            for (int k = 1; k < DEPTH; k++) op_reg[k] <= op_reg[k-1];
        end
    end

    // ---------------- coordinate path ----------------
    logic signed [COORD_WIDTH-1:0] cx, cy, cz;
    logic                          csat;
    logic signed [COORD_WIDTH-1:0] cx_reg [CDLY];
    logic signed [COORD_WIDTH-1:0] cy_reg [CDLY];
    logic signed [COORD_WIDTH-1:0] cz_reg [CDLY];
    logic                          csat_reg [CDLY];

    rtpv_coord_path #(.COORD_WIDTH(COORD_WIDTH)) u_coord (
        .aclk      (aclk),
        .en        (adv),
        .rot       (rot_reg),
        .trans_x   (tx_reg),
        .trans_y   (ty_reg),
        .trans_z   (tz_reg),
        .op        (s_op),
        .x_in      (s_x_in),
        .y_in      (s_y_in),
        .z_in      (s_z_in),
        .x_out     (cx),
        .y_out     (cy),
        .z_out     (cz),
        .saturated (csat)
    );

    // align coordinate results with the yaw path
    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_reg[0]   <= cx;
            cy_reg[0]   <= cy;
            cz_reg[0]   <= cz;
            csat_reg[0] <= csat;
            for (int k = 1; k < CDLY; k++) begin
                cx_reg[k]   <= cx_reg[k-1];
                cy_reg[k]   <= cy_reg[k-1];
                cz_reg[k]   <= cz_reg[k-1];
                csat_reg[k] <= csat_reg[k-1];
            end
        end
    end

    // ---------------- yaw: fold into [-pi/2, pi/2) ----------------
    logic [31:0]          z0_next, z0_reg;
    logic signed [RW-1:0] x0_next, x0_reg;
    logic [31:0]          ang_wide;

    always_comb begin
        ang_wide = {s_angle_in, {(32-ANGLE_WIDTH){1'b0}}};
        if (ang_wide[31] != ang_wide[30]) begin
            x0_next = -(RW'(1) <<< 30);
            z0_next = ang_wide + rtpv_pkg::HALF_TURN;
        end else begin
            x0_next = RW'(1) <<< 30;
            z0_next = ang_wide;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg <= x0_next;
            z0_reg <= z0_next;
        end
    end

    // ---------------- yaw: rotation cells ----------------
    logic signed [RW-1:0] rx [S+1];
    logic signed [RW-1:0] ry [S+1];
    logic [31:0]          rz [S+1];

    assign rx[0] = x0_reg;
    assign ry[0] = '0;
    assign rz[0] = z0_reg;

    for (genvar i = 0; i < S; i++) begin : g_rot
        rtpv_cordic_cell #(.WIDTH(RW), .SHIFT(i), .VECTORING(1'b0)) u_cell (
            .aclk (aclk),
            .en   (adv),
            .x_i  (rx[i]),
            .y_i  (ry[i]),
            .z_i  (rz[i]),
            .x_o  (rx[i+1]),
            .y_o  (ry[i+1]),
            .z_o  (rz[i+1])
        );
    end

    // ---------------- yaw: heading through upper-left 2x2 ----------------
    logic signed [PW-1:0] hp_reg [4];
    logic signed [PW-1:0] hp_next [4];
    logic signed [VW-1:0] hx, hy;
    logic signed [VW-1:0] vx0_reg, vy0_reg;
    logic [31:0]          vz0_reg;
    logic                 zero_reg [S+1];

    always_comb begin
        hp_next[0] = PW'($signed(rot_reg.row0[15:0]))  * PW'(rx[S]);
        hp_next[1] = PW'($signed(rot_reg.row0[31:16])) * PW'(ry[S]);
        hp_next[2] = PW'($signed(rot_reg.row1[15:0]))  * PW'(rx[S]);
        hp_next[3] = PW'($signed(rot_reg.row1[31:16])) * PW'(ry[S]);
        hx = VW'(hp_reg[0]) + VW'(hp_reg[1]);
        hy = VW'(hp_reg[2]) + VW'(hp_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hp_reg <= hp_next;
            // left half-plane: negate and start the angle at pi
            if (hx < 0) begin
                vx0_reg <= -hx;
                vy0_reg <= -hy;
                vz0_reg <= rtpv_pkg::HALF_TURN;
            end else begin
                vx0_reg <= hx;
                vy0_reg <= hy;
                vz0_reg <= '0;
            end
            zero_reg[0] <= (hx == 0) && (hy == 0);
            for (int k = 1; k <= S; k++) zero_reg[k] <= zero_reg[k-1];
        end
    end

    // ---------------- yaw: vectoring cells (atan2) ----------------
    logic signed [VW-1:0] vx [S+1];
    logic signed [VW-1:0] vy [S+1];
    logic [31:0]          vz [S+1];

    assign vx[0] = vx0_reg;
    assign vy[0] = vy0_reg;
    assign vz[0] = vz0_reg;

    for (genvar i = 0; i < S; i++) begin : g_vec
        rtpv_cordic_cell #(.WIDTH(VW), .SHIFT(i), .VECTORING(1'b1)) u_cell (
            .aclk (aclk),
            .en   (adv),
            .x_i  (vx[i]),
            .y_i  (vy[i]),
            .z_i  (vz[i]),
            .x_o  (vx[i+1]),
            .y_o  (vy[i+1]),
            .z_o  (vz[i+1])
        );
    end

    // ---------------- output register ----------------
    logic [31:0] z_round;
    logic [1:0]  op_last;
    logic signed [COORD_WIDTH-1:0] ox_reg, oy_reg, oz_reg;
    logic signed [ANGLE_WIDTH-1:0] oa_reg;
    logic                          osat_reg;

    assign op_last = op_reg[DEPTH-1];
    assign z_round = vz[S] + (32'd1 << (31 - ANGLE_WIDTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ox_reg   <= '0;
            oy_reg   <= '0;
            oz_reg   <= '0;
            oa_reg   <= '0;
            osat_reg <= 1'b0;
            if (op_last == rtpv_pkg::OP_POINT || op_last == rtpv_pkg::OP_VECTOR) begin
                ox_reg   <= cx_reg[CDLY-1];
                oy_reg   <= cy_reg[CDLY-1];
                oz_reg   <= cz_reg[CDLY-1];
                osat_reg <= csat_reg[CDLY-1];
            end else if (op_last == rtpv_pkg::OP_YAW && !zero_reg[S]) begin
                oa_reg <= z_round[31 -: ANGLE_WIDTH];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_x_out     = ox_reg;
    assign m_y_out     = oy_reg;
    assign m_z_out     = oz_reg;
    assign m_angle_out = oa_reg;
    assign m_saturated = osat_reg;
endmodule
`default_nettype wire

[design/rtpv_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// One CORDIC micro-rotation, registered. Rotation mode steers by the sign of
// z, vectoring mode by the sign of y.
module rtpv_cordic_cell #(
    parameter int WIDTH     = 33,
    parameter int SHIFT     = 0,
    parameter bit VECTORING = 1'b0
) (
    input  wire                     aclk,
    input  wire                     en,
    input  wire logic signed [WIDTH-1:0] x_i,
    input  wire logic signed [WIDTH-1:0] y_i,
    input  wire logic [31:0]        z_i,
    output logic signed [WIDTH-1:0] x_o,
    output logic signed [WIDTH-1:0] y_o,
    output logic [31:0]             z_o
);
    localparam logic [31:0] ATAN = rtpv_pkg::atan_angle(5'(SHIFT));

    logic signed [WIDTH-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic [31:0] z_reg, z_next;
    logic        ccw;

    always_comb begin
        dx  = y_i >>> SHIFT;
        dy  = x_i >>> SHIFT;
        ccw = VECTORING ? y_i[WIDTH-1] : ~z_i[31];
        if (ccw) begin
            x_next = x_i - dx;
            y_next = y_i + dy;
            z_next = z_i - ATAN;
        end else begin
            x_next = x_i + dx;
            y_next = y_i - dy;
            z_next = z_i + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_o = x_reg;
    assign y_o = y_reg;
    assign z_o = z_reg;
endmodule
`default_nettype wire

[design/rtpv_coord_path.sv]
`timescale 1ns / 1ps
`default_nettype none
// Matrix times vector, rounding, translation and saturation: three stages.
module rtpv_coord_path #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                           aclk,
    input  wire                           en,
    input  wire rtpv_pkg::rot_t           rot,
    input  wire logic signed [COORD_WIDTH-1:0] trans_x,
    input  wire logic signed [COORD_WIDTH-1:0] trans_y,
    input  wire logic signed [COORD_WIDTH-1:0] trans_z,
    input  wire logic [1:0]               op,
    input  wire logic signed [COORD_WIDTH-1:0] x_in,
    input  wire logic signed [COORD_WIDTH-1:0] y_in,
    input  wire logic signed [COORD_WIDTH-1:0] z_in,
    output logic signed [COORD_WIDTH-1:0] x_out,
    output logic signed [COORD_WIDTH-1:0] y_out,
    output logic signed [COORD_WIDTH-1:0] z_out,
    output logic                          saturated
);
    localparam int PW = COORD_WIDTH + 16;
    localparam int SW = COORD_WIDTH + 18;
    localparam int TW = COORD_WIDTH + 5;
    localparam logic signed [TW-1:0] SAT_HI = {{(TW-COORD_WIDTH+1){1'b0}},
                                               {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;

    logic signed [15:0]   ent [3][3];
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [PW-1:0] prod_next [3][3];
    logic signed [TW-1:0] rsum_reg [3];
    logic signed [TW-1:0] rsum_next [3];
    logic signed [SW-1:0] acc [3];
    logic signed [TW-1:0] tsum [3];
    logic signed [TW-1:0] tr [3];
    logic signed [COORD_WIDTH-1:0] res_reg [3];
    logic signed [COORD_WIDTH-1:0] res_next [3];
    logic [2:0] clip;
    logic       sat_reg;
    logic       pt1_reg, pt2_reg;
    logic signed [COORD_WIDTH-1:0] v [3];

    always_comb begin
        v[0] = x_in;
        v[1] = y_in;
        v[2] = z_in;
        for (int c = 0; c < 3; c++) begin
            ent[0][c] = rot.row0[16*c +: 16];
            ent[1][c] = rot.row1[16*c +: 16];
            ent[2][c] = rot.row2[16*c +: 16];
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r][c] = PW'(ent[r][c]) * PW'(v[c]);
            end
        end
        // sum is exact, then floor((sum + 2^13) / 2^14)
        for (int r = 0; r < 3; r++) begin
            acc[r] = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1]) + SW'(prod_reg[r][2])
                     + SW'(8192);
            rsum_next[r] = TW'(acc[r] >>> 14);
        end
        tr[0] = TW'(trans_x);
        tr[1] = TW'(trans_y);
        tr[2] = TW'(trans_z);
        for (int r = 0; r < 3; r++) begin
            tsum[r] = rsum_reg[r] + (pt2_reg ? tr[r] : '0);
            clip[r] = 1'b1;
            if (tsum[r] > SAT_HI) begin
                res_next[r] = SAT_HI[COORD_WIDTH-1:0];
            end else if (tsum[r] < SAT_LO) begin
                res_next[r] = SAT_LO[COORD_WIDTH-1:0];
            end else begin
                res_next[r] = tsum[r][COORD_WIDTH-1:0];
                clip[r]     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            pt1_reg  <= (op == rtpv_pkg::OP_POINT);
            rsum_reg <= rsum_next;
            pt2_reg  <= pt1_reg;
            res_reg  <= res_next;
            sat_reg  <= |clip;
        end
    end

    assign x_out     = res_reg[0];
    assign y_out     = res_reg[1];
    assign z_out     = res_reg[2];
    assign saturated = sat_reg;
endmodule
`default_nettype wire

[design/rtpv_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module rtpv_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_ready,
    input wire                   m_valid,
    input wire                   m_ready,
    input wire [COORD_WIDTH-1:0] m_x_out,
    input wire [COORD_WIDTH-1:0] m_y_out,
    input wire [COORD_WIDTH-1:0] m_z_out,
    input wire [ANGLE_WIDTH-1:0] m_angle_out,
    input wire                   m_saturated
);
    // output register empties on reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // an empty output register never blocks the input side
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty output");

    // a yaw item carries no coordinates and no clip flag
    a_yaw_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_angle_out != '0 |->
            !m_saturated && m_x_out == '0 && m_y_out == '0 && m_z_out == '0)
        else $error("angle and coordinate results mixed");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_x_out) && $stable(m_angle_out))
        else $error("result changed under stall");
endmodule

bind rigid_transform_point_vector_yaw rtpv_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
) u_rtpv_checker (.*);
`default_nettype wire

[tb/rigid_transform_point_vector_yaw_tb.sv]
`timescale 1ns / 1ps
module rigid_transform_point_vector_yaw_tb;

    localparam int CW = 32;
    localparam int AW = 16;
    localparam int NSTAGE = 16;
    localparam int LATENCY = 2 * NSTAGE + 4;
    localparam int N_RANDOM = 1550;
    localparam int CYCLE_LIMIT = 400000;

    // one result item
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [AW-1:0] ang;
        logic                 sat;
    } xform_res_t;

    // directed row: input item plus optional typed-in result
    typedef struct {
        logic [1:0]           op;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [AW-1:0] ang;
        bit                   fixed;
        xform_res_t           res;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_op = '0;
    logic signed [CW-1:0] s_x_in = '0, s_y_in = '0, s_z_in = '0;
    logic signed [AW-1:0] s_angle_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [CW-1:0] m_x_out, m_y_out, m_z_out;
    logic signed [AW-1:0] m_angle_out;
    logic m_saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;

    rigid_transform_point_vector_yaw #(
        .COORD_WIDTH(CW), .ANGLE_WIDTH(AW), .CORDIC_STAGES(NSTAGE)
    ) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_x_in(s_x_in), .s_y_in(s_y_in), .s_z_in(s_z_in), .s_angle_in(s_angle_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_x_out(m_x_out), .m_y_out(m_y_out), .m_z_out(m_z_out),
        .m_angle_out(m_angle_out), .m_saturated(m_saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // shadow of the block's registers
    logic [47:0] mdl_row [3];
    logic signed [CW-1:0] mdl_trans [3];

    xform_res_t pending_res [$];
    int errors = 0;
    int cycles = 0;
    bit rx_idle_off = 1'b0;   // late part of the run: no receiver stalls
    bit tx_idle_off = 1'b0;
    bit hold_rx = 1'b0;       // long receiver hold-off request
    bit hold_done = 1'b0;

    // arithmetic shift right, floor
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mat_entry(int r, int c);
        logic signed [15:0] e;
        e = mdl_row[r][16*c +: 16];
        return longint'(e);
    endfunction

    function automatic logic signed [CW-1:0] clip_coord(longint v, ref bit flag);
        longint hi, lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            v = hi;
            flag = 1'b1;
        end
        if (v < lo) begin
            v = lo;
            flag = 1'b1;
        end
        return v[CW-1:0];
    endfunction

    function automatic logic [31:0] atan_tab(int i);
        case (i)
            0:  return 32'd536870912;
            1:  return 32'd316933406;
            2:  return 32'd167458907;
            3:  return 32'd85004756;
            4:  return 32'd42667331;
            5:  return 32'd21354465;
            6:  return 32'd10679838;
            7:  return 32'd5340245;
            8:  return 32'd2670163;
            9:  return 32'd1335087;
            10: return 32'd667544;
            11: return 32'd333772;
            12: return 32'd166886;
            13: return 32'd83443;
            14: return 32'd41722;
            15: return 32'd20861;
            16: return 32'd10430;
            17: return 32'd5215;
            18: return 32'd2608;
            19: return 32'd1304;
            20: return 32'd652;
            21: return 32'd326;
            22: return 32'd163;
            23: return 32'd81;
            default: return 32'd0;
        endcase
    endfunction

    // yaw: heading from CORDIC rotation, 2x2 rotate, CORDIC vectoring
    function automatic logic signed [AW-1:0] turn_yaw(logic signed [AW-1:0] a);
        longint hx, hy, dx, dy, px, py;
        logic [31:0] zang;
        logic [1:0] quad;
        hx = longint'(1) <<< 30;
        hy = 0;
        zang = {a, {(32 - AW){1'b0}}};
        quad = zang[31:30];
        if (quad == 2'd1 || quad == 2'd2) begin
            hx = -hx;
            zang = zang + rtpv_pkg::HALF_TURN;
        end
        for (int i = 0; i < NSTAGE; i++) begin
            dx = floor_shr(hy, i);
            dy = floor_shr(hx, i);
            if (zang[31]) begin
                hx += dx; hy -= dy; zang = zang + atan_tab(i);
            end else begin
                hx -= dx; hy += dy; zang = zang - atan_tab(i);
            end
        end
        px = mat_entry(0, 0) * hx + mat_entry(0, 1) * hy;
        py = mat_entry(1, 0) * hx + mat_entry(1, 1) * hy;
        if (px == 0 && py == 0) return '0;
        zang = '0;
        if (px < 0) begin
            px = -px; py = -py; zang = rtpv_pkg::HALF_TURN;
        end
        for (int i = 0; i < NSTAGE; i++) begin
            dx = floor_shr(py, i);
            dy = floor_shr(px, i);
            if (py < 0) begin
                px -= dx; py += dy; zang = zang - atan_tab(i);
            end else begin
                px += dx; py -= dy; zang = zang + atan_tab(i);
            end
        end
        zang = zang + (32'd1 << (31 - AW));
        return zang[31 -: AW];
    endfunction

    function automatic xform_res_t predict_xform(logic [1:0] op, logic signed [CW-1:0] x,
                                                 logic signed [CW-1:0] y,
                                                 logic signed [CW-1:0] z,
                                                 logic signed [AW-1:0] a);
        xform_res_t r;
        longint v [3];
        longint q, s;
        longint p;
        longint frac;
        bit flag;
        logic signed [CW-1:0] c [3];
        r = '0;
        flag = 1'b0;
        if (op == rtpv_pkg::OP_POINT || op == rtpv_pkg::OP_VECTOR) begin
            v[0] = longint'(x); v[1] = longint'(y); v[2] = longint'(z);
            for (int row = 0; row < 3; row++) begin
                q = 0;
                frac = 0;
                for (int j = 0; j < 3; j++) begin
                    p = mat_entry(row, j) * v[j];
                    q += floor_shr(p, 14);
                    frac += p & 64'h3FFF;
                end
                s = q + ((frac + 8192) >>> 14);
                if (op == rtpv_pkg::OP_POINT) s += longint'(mdl_trans[row]);
                c[row] = clip_coord(s, flag);
            end
            r.x = c[0]; r.y = c[1]; r.z = c[2];
            r.sat = flag;
        end else if (op == rtpv_pkg::OP_YAW) begin
            r.ang = turn_yaw(a);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // receiver: random stall bursts, long hold-off on request, checking
    // ---------------------------------------------------------------------
    initial begin : rx_proc
        int stall;
        int hold_cnt;
        stall = 0;
        hold_cnt = 0;
        forever begin
            @(negedge aclk);
            if (hold_rx && !hold_done) begin
                // hold off long enough for the pipeline to fill and stall input
                m_ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= 3 * LATENCY) hold_done = 1'b1;
            end else if (rx_idle_off || !aresetn) begin
                m_ready <= aresetn;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 5) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        xform_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_res.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                want = pending_res.pop_front();
                if (m_x_out !== want.x) begin
                    $error("x_out expected %0d got %0d", want.x, m_x_out);
                    errors++;
                end
                if (m_y_out !== want.y) begin
                    $error("y_out expected %0d got %0d", want.y, m_y_out);
                    errors++;
                end
                if (m_z_out !== want.z) begin
                    $error("z_out expected %0d got %0d", want.z, m_z_out);
                    errors++;
                end
                if (m_angle_out !== want.ang) begin
                    $error("angle_out expected %0d got %0d", want.ang, m_angle_out);
                    errors++;
                end
                if (m_saturated !== want.sat) begin
                    $error("saturated expected %0d got %0d", want.sat, m_saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------------
    // one item: optional idle burst, then hold valid until accepted
    task automatic push_item(logic [1:0] op, logic signed [CW-1:0] x,
                             logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                             logic signed [AW-1:0] a, bit fixed, xform_res_t fres);
        int gap;
        if (!tx_idle_off && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op; s_x_in <= x; s_y_in <= y; s_z_in <= z; s_angle_in <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_res.push_back(fixed ? fres : predict_xform(op, x, y, z, a));
        @(negedge aclk);
    endtask

    // idle: drop valid, drain, then the latency pause for safety
    task automatic drain_all();
        s_valid <= 1'b0;
        while (pending_res.size() != 0) @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            rtpv_pkg::CFG_ROT_ROW0: mdl_row[0] = val;
            rtpv_pkg::CFG_ROT_ROW1: mdl_row[1] = val;
            rtpv_pkg::CFG_ROT_ROW2: mdl_row[2] = val;
            rtpv_pkg::CFG_TRANS_X:  mdl_trans[0] = val[CW-1:0];
            rtpv_pkg::CFG_TRANS_Y:  mdl_trans[1] = val[CW-1:0];
            rtpv_pkg::CFG_TRANS_Z:  mdl_trans[2] = val[CW-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] q14(int v);
        return 16'(v);
    endfunction

    function automatic logic [47:0] pack_row(int c0, int c1, int c2);
        return {q14(c2), q14(c1), q14(c0)};
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // random coordinate: mostly moderate, sometimes extreme
    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    // random rotation entries: mix of Q2.14 unit-ish values and full range
    function automatic logic [47:0] rand_row();
        case ($urandom_range(0, 3))
            0: return rand48();
            1: return pack_row(16384, 0, 0);
            default: return pack_row($urandom_range(0, 32767) - 16384,
                                     $urandom_range(0, 32767) - 16384,
                                     $urandom_range(0, 32767) - 16384);
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [1:0] op;
        for (int k = 0; k < n; k++) begin
            op = 2'($urandom_range(0, 3));
            push_item(op, rand_coord(), rand_coord(), rand_coord(),
                      16'($urandom), 1'b0, '0);
        end
    endtask

    dir_row_t dir_tab [$];

    task automatic add_row(logic [1:0] op, int x, int y, int z, int a,
                           bit fixed, xform_res_t r);
        dir_row_t d;
        d.op = op; d.x = x; d.y = y; d.z = z; d.ang = 16'(a);
        d.fixed = fixed; d.res = r;
        dir_tab.push_back(d);
    endtask

    initial begin : tx_proc
        xform_res_t r;
        mdl_row[0] = rtpv_pkg::ROW0_RST;
        mdl_row[1] = rtpv_pkg::ROW1_RST;
        mdl_row[2] = rtpv_pkg::ROW2_RST;
        mdl_trans[0] = '0; mdl_trans[1] = '0; mdl_trans[2] = '0;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table under reset configuration (identity, no translation)
        r = '0; r.x = 32'sd65536; r.y = -32'sd65536; r.z = 32'sd7;
        add_row(rtpv_pkg::OP_POINT, 65536, -65536, 7, 0, 1'b1, r);
        r = '0; r.x = 32'sh7FFF_FFFF; r.y = 32'sh8000_0000; r.z = 0;
        add_row(rtpv_pkg::OP_VECTOR, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 12345, 1'b1, r);
        r = '0;
        add_row(2'd3, 5, 6, 7, 100, 1'b1, r);      // unused op code: all zero
        r = '0; r.ang = 16'sd0;
        add_row(rtpv_pkg::OP_YAW, 99, 99, 99, 0, 1'b0, r);
        add_row(rtpv_pkg::OP_YAW, 0, 0, 0, 16384, 1'b0, r);
        add_row(rtpv_pkg::OP_YAW, 0, 0, 0, -32768, 1'b0, r);
        add_row(rtpv_pkg::OP_YAW, 0, 0, 0, 32767, 1'b0, r);
        add_row(rtpv_pkg::OP_YAW, 0, 0, 0, -16384, 1'b0, r);
        add_row(rtpv_pkg::OP_YAW, 0, 0, 0, -16385, 1'b0, r);
        foreach (dir_tab[i])
            push_item(dir_tab[i].op, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                      dir_tab[i].ang, dir_tab[i].fixed, dir_tab[i].res);
        drain_all();

        // extremes: full-scale matrix and translation, saturation both ways
        write_reg(rtpv_pkg::CFG_ROT_ROW0, pack_row(32767, 32767, 32767));
        write_reg(rtpv_pkg::CFG_ROT_ROW1, pack_row(-32768, -32768, -32768));
        write_reg(rtpv_pkg::CFG_ROT_ROW2, pack_row(-32768, 32767, 0));
        write_reg(rtpv_pkg::CFG_TRANS_X, 48'h0000_7FFF_FFFF);
        write_reg(rtpv_pkg::CFG_TRANS_Y, 48'h0000_8000_0000);
        write_reg(rtpv_pkg::CFG_TRANS_Z, 48'hFFFF_FFFF_FFFF);
        write_reg(3'd6, 48'h1234_5678_9ABC);       // out-of-range index: ignored
        dir_tab.delete();
        add_row(rtpv_pkg::OP_POINT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0,
                1'b0, r);
        add_row(rtpv_pkg::OP_POINT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0,
                1'b0, r);
        add_row(rtpv_pkg::OP_VECTOR, -1, 1, -1, -1, 1'b0, r);
        add_row(rtpv_pkg::OP_POINT, 0, 0, 0, 0, 1'b0, r);
        add_row(rtpv_pkg::OP_YAW, 0, 0, 0, 8192, 1'b0, r);
        add_row(rtpv_pkg::OP_YAW, 0, 0, 0, -8192, 1'b0, r);
        foreach (dir_tab[i])
            push_item(dir_tab[i].op, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                      dir_tab[i].ang, dir_tab[i].fixed, dir_tab[i].res);
        drain_all();

        // vanishing heading: zero upper-left 2x2
        write_reg(rtpv_pkg::CFG_ROT_ROW0, pack_row(0, 0, 16384));
        write_reg(rtpv_pkg::CFG_ROT_ROW1, pack_row(0, 0, -16384));
        r = '0;
        push_item(rtpv_pkg::OP_YAW, 0, 0, 0, 1234, 1'b1, r);
        push_item(rtpv_pkg::OP_YAW, 0, 0, 0, -32768, 1'b1, r);
        drain_all();

        // random phases, each with a fresh configuration
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(rtpv_pkg::CFG_ROT_ROW0, rand_row());
            write_reg(rtpv_pkg::CFG_ROT_ROW1, rand_row());
            write_reg(rtpv_pkg::CFG_ROT_ROW2, rand_row());
            write_reg(rtpv_pkg::CFG_TRANS_X, rand48());
            write_reg(rtpv_pkg::CFG_TRANS_Y, rand48());
            write_reg(rtpv_pkg::CFG_TRANS_Z, rand48());
            if (ph == 2) hold_rx = 1'b1;   // receiver backs off while items keep coming
            if (ph == 7) begin
                rx_idle_off = 1'b1;
                tx_idle_off = 1'b1;
            end
            random_phase(N_RANDOM / 8);
            drain_all();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
